[hdl/aes_ctr_pkg.sv]
// Package for the AES-128 counter-mode stream unit.
// Holds widths, register indexes, the S-box and the GF(2^8) helpers.
// Used by every file in hdl/.
package aes_ctr_pkg;
	localparam int ROUND_COUNT = 10;
	localparam int WORD_W = 64;
	localparam int BLOCK_W = 128;
	localparam int COUNT_W = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CTR_HIGH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CTR_LOW = 2'd3;

	typedef logic [BLOCK_W-1:0] block_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [15:0] keep;
	} side_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] blk_byte(input block_t b, input int j);
		return b[BLOCK_W-1-8*j -: 8];
	endfunction
endpackage

[hdl/aes_ctr_if.sv]
// Valid/ready stream and configuration channel interfaces.
// Depends on aes_ctr_pkg.
interface aes_ctr_in_if;
	logic valid;
	logic ready;
	logic [aes_ctr_pkg::WORD_W-1:0] data_high;
	logic [aes_ctr_pkg::WORD_W-1:0] data_low;
	logic [aes_ctr_pkg::COUNT_W-1:0] byte_count;
	logic restart;
	modport source(output valid, data_high, data_low, byte_count, restart, input ready);
	modport sink(input valid, data_high, data_low, byte_count, restart, output ready);
endinterface

interface aes_ctr_out_if;
	logic valid;
	logic ready;
	logic [aes_ctr_pkg::WORD_W-1:0] result_high;
	logic [aes_ctr_pkg::WORD_W-1:0] result_low;
	logic [aes_ctr_pkg::COUNT_W-1:0] result_count;
	modport source(output valid, result_high, result_low, result_count, input ready);
	modport sink(input valid, result_high, result_low, result_count, output ready);
endinterface

interface aes_ctr_cfg_if;
	logic valid;
	logic ready;
	logic [aes_ctr_pkg::CFG_IDX_W:0] index;
	logic [aes_ctr_pkg::WORD_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hdl/aes_ctr_round_cell.sv]
// One AES round cell: round-key schedule step plus one cipher round.
// Passes state, round key, data and sideband to the next cell each cycle that en is high.
// Depends on aes_ctr_pkg.
module aes_ctr_round_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [7:0]              rcon,
	input  logic                    last,
	input  logic                    vld_in,
	input  aes_ctr_pkg::block_t     st_in,
	input  aes_ctr_pkg::block_t     rk_in,
	input  aes_ctr_pkg::block_t     dat_in,
	input  aes_ctr_pkg::side_t      side_in,
	output logic                    vld_out,
	output aes_ctr_pkg::block_t     st_out,
	output aes_ctr_pkg::block_t     rk_out,
	output aes_ctr_pkg::block_t     dat_out,
	output aes_ctr_pkg::side_t      side_out
);
	aes_ctr_pkg::block_t rk_nxt, sr, mc;
	logic [31:0] w [4];
	logic [31:0] tw;
	logic [7:0] a0, a1, a2, a3, e;

	always_comb begin
		tw = {aes_ctr_pkg::sbox(rk_in[23:16]) ^ rcon, aes_ctr_pkg::sbox(rk_in[15:8]),
			aes_ctr_pkg::sbox(rk_in[7:0]), aes_ctr_pkg::sbox(rk_in[31:24])};
		w[0] = rk_in[127:96] ^ tw;
		w[1] = rk_in[95:64] ^ w[0];
		w[2] = rk_in[63:32] ^ w[1];
		w[3] = rk_in[31:0] ^ w[2];
		rk_nxt = {w[0], w[1], w[2], w[3]};
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				sr[127-8*(4*c+i) -: 8] =
					aes_ctr_pkg::sbox(aes_ctr_pkg::blk_byte(st_in, 4*((c+i)%4)+i));
			end
		end
		mc = sr;
		for (int c = 0; c < 4; c++) begin
			a0 = sr[127-32*c -: 8];
			a1 = sr[119-32*c -: 8];
			a2 = sr[111-32*c -: 8];
			a3 = sr[103-32*c -: 8];
			e = a0 ^ a1 ^ a2 ^ a3;
			mc[127-32*c -: 32] = {a0 ^ e ^ aes_ctr_pkg::xtime(a0 ^ a1),
				a1 ^ e ^ aes_ctr_pkg::xtime(a1 ^ a2),
				a2 ^ e ^ aes_ctr_pkg::xtime(a2 ^ a3),
				a3 ^ e ^ aes_ctr_pkg::xtime(a3 ^ a0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_out <= (last ? sr : mc) ^ rk_nxt;
			rk_out <= rk_nxt;
			dat_out <= dat_in;
			side_out <= side_in;
		end
	end
endmodule

[hdl/aes_ctr_stream_unit.sv]
// Top level: config registers, counter, chain of ten round cells, output stage.
// Depends on aes_ctr_pkg, aes_ctr_if and aes_ctr_round_cell.
//
// AES-128 counter-mode stream unit.
// Channels: in (data_high/low, byte_count, restart), out (result_high/low,
// result_count), cfg (index, data) for key and counter start registers.
// Each accepted request is encrypted by a chain of ten round cells, one round
// per cell, and the keystream is XORed into the data at the output register.
// A request passes through the ten round cells and then the output register.
// Throughput: one 16-byte block per cycle while the chain is not stalled; the round chain sets this figure.
// Key schedule is computed in the chain alongside the data, so key writes take
// effect on the next request.
// The whole chain stalls when the output register holds a result and out.ready
// is low; in.ready follows, and no slot advances, empty or not.
// Reset clears keys, counter start, running counter and all valid bits.
// Configure only while the chain is empty.
module aes128_ctr_stream_unit (
	input logic clk,
	input logic arst_n,
	aes_ctr_in_if.sink in,
	aes_ctr_out_if.source out,
	aes_ctr_cfg_if.sink cfg
);
	localparam int N = aes_ctr_pkg::ROUND_COUNT;
	localparam logic [7:0] RCON [N] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
		8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

	logic [aes_ctr_pkg::WORD_W-1:0] key_high_q, key_low_q, ctr_high_q, ctr_low_q;
	aes_ctr_pkg::block_t ctr_q, ctr_use, key;
	logic [N:0] vld;
	aes_ctr_pkg::block_t st [N+1];
	aes_ctr_pkg::block_t rk [N+1];
	aes_ctr_pkg::block_t dat [N+1];
	aes_ctr_pkg::side_t side [N+1];
	aes_ctr_pkg::side_t side_in;
	aes_ctr_pkg::block_t res;
	logic en, acc, full;
	logic out_vld_q;

	assign en = !out_vld_q || out.ready;
	assign in.ready = en;
	assign cfg.ready = 1'b1;
	assign acc = in.valid && in.ready;
	assign key = {key_high_q, key_low_q};
	assign ctr_use = in.restart ? {ctr_high_q, ctr_low_q} : ctr_q;
	assign full = in.byte_count >= 5'd16;

	always_comb begin
		side_in.count = in.byte_count;
		for (int j = 0; j < 16; j++) begin
			side_in.keep[15-j] = full || (5'(j) < in.byte_count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			ctr_high_q <= '0;
			ctr_low_q <= '0;
			ctr_q <= '0;
		end else begin
			if (cfg.valid && cfg.index[aes_ctr_pkg::CFG_IDX_W] == 1'b0) begin
				unique case (cfg.index[aes_ctr_pkg::CFG_IDX_W-1:0])
					aes_ctr_pkg::REG_KEY_HIGH: key_high_q <= cfg.data;
					aes_ctr_pkg::REG_KEY_LOW:  key_low_q <= cfg.data;
					aes_ctr_pkg::REG_CTR_HIGH: ctr_high_q <= cfg.data;
					aes_ctr_pkg::REG_CTR_LOW:  ctr_low_q <= cfg.data;
					default: ;
				endcase
			end
			if (acc) begin
				ctr_q <= full ? ctr_use + 128'd1 : ctr_use;
			end
		end
	end

	assign vld[0] = acc;
	assign st[0] = ctr_use ^ key;
	assign rk[0] = key;
	assign dat[0] = {in.data_high, in.data_low};
	assign side[0] = side_in;

	for (genvar g = 0; g < N; g++) begin : g_cell
		aes_ctr_round_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .rcon(RCON[g]), .last(g == N-1),
			.vld_in(vld[g]), .st_in(st[g]), .rk_in(rk[g]), .dat_in(dat[g]),
			.side_in(side[g]), .vld_out(vld[g+1]), .st_out(st[g+1]),
			.rk_out(rk[g+1]), .dat_out(dat[g+1]), .side_out(side[g+1])
		);
	end

	always_comb begin
		for (int j = 0; j < 16; j++) begin
			res[127-8*j -: 8] = side[N].keep[15-j] ?
				(st[N][127-8*j -: 8] ^ dat[N][127-8*j -: 8]) : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld[N]) begin
			out.result_high <= res[127:64];
			out.result_low <= res[63:0];
			out.result_count <= side[N].count;
		end
	end

	assign out.valid = out_vld_q;

`ifndef ASSERT_OFF
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.result_high))
		else $error("result changed under stall");
	a_ready_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		in.ready == (!out.valid || out.ready))
		else $error("input ready mismatch");
	a_partial_hold: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !full && !in.restart |=> $stable(ctr_q))
		else $error("counter advanced on partial block");
`endif
endmodule
